// ===== sv/dane_pkg.sv =====
// Shared types, constants and the step scale table for the delta ADPCM encoder.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package dane_pkg;

	localparam int SampleW = 16;
	localparam int PredW   = 20;
	localparam int StepW   = 15;
	localparam int MagW    = 3;
	localparam int CodeW   = 4;
	localparam int ByteW   = 8;
	localparam int ScaleW  = 8;
	localparam int RemW    = 19;

	localparam logic [StepW-1:0] STEP_MIN = 15'd127;
	localparam logic [StepW-1:0] STEP_MAX = 15'd24576;

	typedef struct packed {
		logic load;     // take a request, form |diff|, apply start of stream
		logic div_hi;   // saturation check and quotient bit 2
		logic div_lo;   // quotient bits 1 and 0
		logic update;   // move prediction, rescale step, pack the code
	} dane_cmd_t;

	typedef struct packed {
		logic odd;      // next code completes a byte
	} dane_status_t;

	function automatic logic [ScaleW-1:0] scale_for_mag(input logic [MagW-1:0] m);
		logic [ScaleW-1:0] f;
		unique case (m)
			3'd4:    f = 8'd77;
			3'd5:    f = 8'd102;
			3'd6:    f = 8'd128;
			3'd7:    f = 8'd153;
			default: f = 8'd57;
		endcase
		return f;
	endfunction

endpackage

// ===== sv/delta_adpcm_nibble_encoder_unit.sv =====
// Delta ADPCM (delta-T) nibble encoder, top level: controller plus datapath.
// Each sample request passes through accept, two divide steps and update; no new request is taken until its update.
// A completing sample shows its byte once its update has run; the byte and out_valid are registered at that update.
// One byte comes out per two samples; a stalled byte holds only the next odd update.
// Reset (arst_n low, asynchronous): prediction 0, step 127, no held nibble, no output.
// Depends on dane_pkg, dane_ctrl and dane_dp.
`timescale 1ns / 1ps

module delta_adpcm_nibble_encoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample,
	input  logic               start_of_stream,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         packed_byte
);
	import dane_pkg::*;

	// Command bundle from the sequencer, phase status back from the datapath.
	dane_cmd_t    cmd;
	dane_status_t st;

	// Sequencer: takes a request in idle, steps the 3-bit quotient through
	// two divide states (saturation and bit 2, then bits 1 and 0), then updates. The
	// update of an odd sample waits while the previous byte is still stalled.
	dane_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath: forms |sample - prediction| at the accept edge, divides by the
	// step with restoring compare-subtract, then moves the prediction and
	// rescales the step through the table, and packs two codes per byte.
	dane_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.sample          (sample),
		.start_of_stream (start_of_stream),
		.packed_byte     (packed_byte)
	);

endmodule

// ===== sv/dane_dp.sv =====
// Datapath of the delta ADPCM encoder: prediction, step size, quotient and packing.
// Depends on dane_pkg; sequenced by dane_ctrl through dane_cmd_t.
`timescale 1ns / 1ps

module dane_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dane_pkg::dane_cmd_t             cmd,
	output dane_pkg::dane_status_t          st,
	input  logic signed [15:0]              sample,
	input  logic                            start_of_stream,
	output logic [7:0]                      packed_byte
);
	import dane_pkg::*;

	logic signed [PredW-1:0] pred_q;
	logic [StepW-1:0]        step_q;
	logic [CodeW-1:0]        held_q;
	logic                    odd_q;
	logic                    neg_q;
	logic                    sat_q;
	logic                    q2_q;
	logic [MagW-1:0]         qmag_q;
	logic [RemW-1:0]         rem_q;
	logic [ByteW-1:0]        byte_q;

	logic signed [PredW-1:0] pred_eff;
	logic [PredW:0]          diff;
	logic [PredW:0]          mag;
	logic [RemW-1:0]         s3, s2, s1, s0;
	logic                    sat, q2, q1, q0;
	logic [RemW-1:0]         rem_hi, rem_mid;
	logic [CodeW-1:0]        odd_mult;
	logic [RemW-1:0]         prod_move;
	logic [15:0]             move;
	logic [22:0]             prod_scale;
	logic [16:0]             scaled;
	logic [StepW-1:0]        step_next;
	logic signed [PredW-1:0] pred_next;
	logic [CodeW-1:0]        code;

	// start of stream: encode against the cleared prediction
	assign pred_eff = start_of_stream ? '0 : pred_q;
	assign diff = {{(PredW+1-SampleW){sample[SampleW-1]}}, sample}
	            - {pred_eff[PredW-1], pred_eff};
	assign mag  = diff[PredW] ? (~diff + 1'b1) : diff;

	assign s3 = {1'b0, step_q, 3'b000};
	assign s2 = {2'b00, step_q, 2'b00};
	assign s1 = {3'b000, step_q, 1'b0};
	assign s0 = {4'b0000, step_q};

	assign sat    = rem_q >= s3;
	assign q2     = rem_q >= s2;
	assign rem_hi = q2 ? rem_q - s2 : rem_q;

	assign q1      = rem_q >= s1;
	assign rem_mid = q1 ? rem_q - s1 : rem_q;
	assign q0      = rem_mid >= s0;

	assign odd_mult  = {qmag_q, 1'b1};
	assign prod_move = RemW'(odd_mult) * RemW'(step_q);
	assign move      = prod_move[RemW-1:3];
	assign pred_next = neg_q ? pred_q - $signed({4'b0000, move})
	                         : pred_q + $signed({4'b0000, move});

	assign prod_scale = 23'(scale_for_mag(qmag_q)) * 23'(step_q);
	assign scaled     = prod_scale[22:6];
	always_comb begin
		if (scaled < 17'(STEP_MIN)) begin
			step_next = STEP_MIN;
		end else if (scaled > 17'(STEP_MAX)) begin
			step_next = STEP_MAX;
		end else begin
			step_next = scaled[StepW-1:0];
		end
	end

	assign code = {neg_q, qmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q <= '0;
			step_q <= STEP_MIN;
			held_q <= '0;
			odd_q  <= 1'b0;
		end else if (cmd.load && start_of_stream) begin
			pred_q <= '0;
			step_q <= STEP_MIN;
			held_q <= '0;
			odd_q  <= 1'b0;
		end else if (cmd.update) begin
			pred_q <= pred_next;
			step_q <= step_next;
			odd_q  <= ~odd_q;
			if (!odd_q) begin
				held_q <= code;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= diff[PredW];
			rem_q <= {mag[16:0], 2'b00};
		end
		if (cmd.div_hi) begin
			sat_q <= sat;
			q2_q  <= q2;
			rem_q <= rem_hi;
		end
		if (cmd.div_lo) begin
			qmag_q <= sat_q ? 3'd7 : {q2_q, q1, q0};
		end
		if (cmd.update && odd_q) begin
			byte_q <= {held_q, code};
		end
	end

	assign st.odd      = odd_q;
	assign packed_byte = byte_q;

endmodule

// ===== sv/dane_ctrl.sv =====
// Sequencer of the delta ADPCM encoder: request handshake, step order, output valid.
// Depends on dane_pkg; drives dane_dp through dane_cmd_t.
`timescale 1ns / 1ps

module dane_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  dane_pkg::dane_status_t st,
	output dane_pkg::dane_cmd_t    cmd
);
	import dane_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV_HI,
		S_DIV_LO,
		S_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_busy;
	logic   upd_go;

	// a byte still waiting downstream blocks the next byte only
	assign out_busy = out_valid_q && out_stall;
	assign upd_go   = (state_q == S_UPD) && !(st.odd && out_busy);

	assign in_stall   = (state_q != S_IDLE);
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.div_hi = (state_q == S_DIV_HI);
	assign cmd.div_lo = (state_q == S_DIV_LO);
	assign cmd.update = upd_go;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (upd_go && st.odd) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DIV_HI;
					end
				end
				S_DIV_HI: state_q <= S_DIV_LO;
				S_DIV_LO: state_q <= S_UPD;
				S_UPD: begin
					if (upd_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_load_starts_divide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DIV_HI))
		else $error("accepted request did not enter the divide");
	a_divide_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_LO) |=> (state_q == S_UPD))
		else $error("divide did not advance to update");
	a_byte_after_odd_update: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && st.odd) |=> out_valid_q)
		else $error("completed byte not presented");
	a_valid_only_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.update && st.odd))
		else $error("output valid rose without a completed byte");
`endif

endmodule
